FILE: design/lpf3_pkg.sv
package lpf3_pkg;

  localparam int AXES = 3;

  localparam int CUT_W  = 24;
  localparam int TS_W   = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CUT_W-1:0] CUT_RESET = 24'd2560;
  localparam logic [TS_W-1:0]  TS_RESET  = 32'd4294967;

  localparam logic REG_CUTOFF = 1'b0;
  localparam logic REG_TSTEP  = 1'b1;

  // coefficient arithmetic
  localparam int P_W   = CUT_W + TS_W;
  localparam int K_W   = P_W - 8;
  localparam int R_W   = K_W + 1;
  localparam int B_W   = 31;
  localparam int CNT_W = 5;
  localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;
  localparam logic [R_W-1:0] DEN_ONE = {{(R_W-31){1'b0}}, 1'b1, 30'b0};

  // serial multiply in the lanes
  localparam int MUL_STEPS = B_W;
  localparam int RND_STEP  = 29;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_FIN
  } lpf3_state_t;

  typedef enum logic [1:0] {
    C_PROD,
    C_PI,
    C_DIV,
    C_DONE
  } lpf3_coef_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic rnd;
    logic last;
    logic commit;
    logic bypass;
  } lpf3_lane_ctl_t;

endpackage

FILE: design/lpf3_coef.sv
module lpf3_coef (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic [lpf3_pkg::CUT_W-1:0]   cutoff_freq,
  input  logic [lpf3_pkg::TS_W-1:0]    time_step,
  output logic [lpf3_pkg::B_W-1:0]     coef_b,
  output logic                         coef_ready
);
  import lpf3_pkg::*;

  lpf3_coef_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [P_W-1:0]   prod_r, prod_nxt;
  logic [P_W-1:0]   pk_r, pk_nxt;
  logic [R_W-1:0]   rem_r, rem_nxt;
  logic [B_W-1:0]   q_r, q_nxt;

  logic [CNT_W-1:0] cut_idx;
  logic [P_W:0]     pi_sum;
  logic [R_W-1:0]   den;
  logic [R_W:0]     rem2;
  logic [R_W:0]     diff;
  logic             ge;
  logic [B_W:0]     q_inc;

  assign cut_idx = CNT_W'(CUT_W - 1) - cnt_r;
  assign pi_sum  = {1'b0, pk_r} + (PI_Q30[cnt_r] ? {1'b0, prod_r} : '0);
  assign den     = DEN_ONE + {1'b0, pk_r[P_W-1:8]};
  assign rem2    = {rem_r, 1'b0};
  assign diff    = rem2 - {1'b0, den};
  assign ge      = rem2 >= {1'b0, den};
  assign q_inc   = {1'b0, q_r} + {{B_W{1'b0}}, 1'b1};

  // next state
  always_comb begin
    state_nxt = state_r;
    if (restart) begin
      state_nxt = C_PROD;
    end else begin
      case (state_r)
        C_PROD: if (cnt_r == CNT_W'(CUT_W - 1)) state_nxt = C_PI;
        C_PI:   if (cnt_r == CNT_W'(31)) state_nxt = C_DIV;
        C_DIV:  if (cnt_r == CNT_W'(B_W - 1)) state_nxt = C_DONE;
        C_DONE: state_nxt = C_DONE;
        default: state_nxt = C_PROD;
      endcase
    end
  end

  // datapath
  always_comb begin
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    pk_nxt   = pk_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (restart) begin
      cnt_nxt  = '0;
      prod_nxt = '0;
    end else begin
      case (state_r)
        C_PROD: begin
          prod_nxt = {prod_r[P_W-2:0], 1'b0} + (cutoff_freq[cut_idx] ? P_W'(time_step) : '0);
          if (cnt_r == CNT_W'(CUT_W - 1)) begin
            cnt_nxt = '0;
            pk_nxt  = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        C_PI: begin
          pk_nxt  = pi_sum[P_W:1];
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(31)) begin
            rem_nxt = {1'b0, pi_sum[P_W:9]};
            q_nxt   = '0;
          end
        end
        C_DIV: begin
          rem_nxt = ge ? diff[R_W-1:0] : rem2[R_W-1:0];
          q_nxt   = {q_r[B_W-2:0], ge};
          cnt_nxt = cnt_r + 1'b1;
        end
        C_DONE: begin
          cnt_nxt = cnt_r;
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_PROD;
      cnt_r   <= '0;
      prod_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      prod_r  <= prod_nxt;
    end
    pk_r  <= pk_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign coef_b     = q_inc[B_W:1];
  assign coef_ready = (state_r == C_DONE);

endmodule

FILE: design/lpf3_lane.sv
module lpf3_lane #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  lpf3_pkg::lpf3_lane_ctl_t       ctl,
  input  logic [lpf3_pkg::B_W-1:0]       coef_b,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] filtered
);
  import lpf3_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int DW = SW + 2;
  localparam int AW = SW + 3;
  localparam int YW = SW + 4;

  logic signed [SW-1:0] x_prev_r, y_prev_r, x_cur_r;
  logic signed [DW-1:0] d_r;
  logic signed [AW-1:0] acc_r;
  logic [B_W-1:0]       b_sh_r;

  logic signed [DW-1:0] d_nxt;
  logic signed [AW-1:0] addend, sum, acc_nxt;
  logic signed [YW-1:0] y_full;
  logic                 y_ok;
  logic signed [SW-1:0] y_sat;

  // d = x + x_prev - 2*y_prev
  assign d_nxt = {{2{sample[SW-1]}}, sample} + {{2{x_prev_r[SW-1]}}, x_prev_r}
               - {y_prev_r[SW-1], y_prev_r, 1'b0};

  // one bit of b per cycle, lsb first, floor shift
  assign addend  = b_sh_r[0] ? {{(AW-DW){d_r[DW-1]}}, d_r} : '0;
  assign sum     = acc_r + addend + {{(AW-1){1'b0}}, ctl.rnd};
  assign acc_nxt = ctl.last ? sum : {sum[AW-1], sum[AW-1:1]};

  assign y_full = {{(YW-SW){y_prev_r[SW-1]}}, y_prev_r} + {{(YW-AW){acc_r[AW-1]}}, acc_r};
  assign y_ok   = (&y_full[YW-1:SW-1]) | ~(|y_full[YW-1:SW-1]);
  assign y_sat  = y_ok ? y_full[SW-1:0] : {y_full[YW-1], {(SW-1){~y_full[YW-1]}}};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_cur_r <= sample;
      d_r     <= d_nxt;
      acc_r   <= '0;
      b_sh_r  <= coef_b;
    end else if (ctl.step) begin
      acc_r  <= acc_nxt;
      b_sh_r <= {1'b0, b_sh_r[B_W-1:1]};
    end
    if (ctl.commit) begin
      x_prev_r <= x_cur_r;
      y_prev_r <= ctl.bypass ? x_cur_r : y_sat;
    end
  end

  assign filtered = y_prev_r;

endmodule

FILE: design/first_order_lowpass_3axis.sv
// three-axis first-order low-pass filter, bilinear form, Q16.16 samples
// input channel: in_valid/in_ready carry one sample per axis and a restart bit;
// restart (or the first request after reset) passes the samples straight through
// result channel: out_valid/out_ready carry the filtered vector, one per request
// config: apb-style write port, cutoff_freq at 0x0, time_step at 0x4, pready tied high
// each config write, and reset, start a coefficient calculation (24 product steps,
// 32 pi steps, 31 division steps) during which in_ready is low
// a request runs as a load, the bit-serial multiply (one bit of the coefficient
// per cycle, all axes in parallel lanes) and a commit; out_valid rises the cycle
// after commit, so the next request can be accepted while a result waits in the
// output register
// if the receiver stalls, a finished request holds in the commit cycle until the
// output register is taken, and in_ready stays low meanwhile
// reset (rst_n low, synchronous) clears the handshakes and restores cutoff 10 Hz
module first_order_lowpass_3axis #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_x_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_y_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_z_sample,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    out_x_filtered,
  output logic signed [SAMPLE_WIDTH-1:0]    out_y_filtered,
  output logic signed [SAMPLE_WIDTH-1:0]    out_z_filtered,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpf3_pkg::ADDR_W-1:0]       paddr,
  input  logic [lpf3_pkg::DATA_W-1:0]       pwdata,
  output logic [lpf3_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import lpf3_pkg::*;

  lpf3_state_t    state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           first_pending_r, first_pending_nxt;
  logic           bypass_r, bypass_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CUT_W-1:0] cutoff_r;
  logic [TS_W-1:0]  tstep_r;

  logic           cfg_wr;
  logic           coef_ready;
  logic [B_W-1:0] coef_b;
  logic           accept;
  logic           slot_free;
  logic           mul_last;
  lpf3_lane_ctl_t lane_ctl;

  logic signed [SAMPLE_WIDTH-1:0] lane_in  [AXES];
  logic signed [SAMPLE_WIDTH-1:0] lane_out [AXES];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_TSTEP) ? tstep_r : {{(DATA_W-CUT_W){1'b0}}, cutoff_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUT_RESET;
      tstep_r  <= TS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CUTOFF) begin
        cutoff_r <= pwdata[CUT_W-1:0];
      end else begin
        tstep_r <= pwdata[TS_W-1:0];
      end
    end
  end

  lpf3_coef u_coef (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (cfg_wr),
    .cutoff_freq (cutoff_r),
    .time_step   (tstep_r),
    .coef_b      (coef_b),
    .coef_ready  (coef_ready)
  );

  assign in_ready  = (state_r == S_IDLE) && coef_ready;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign mul_last  = (cnt_r == CNT_W'(MUL_STEPS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MUL;
      S_MUL:   if (mul_last) state_nxt = S_FIN;
      S_FIN:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    lane_ctl          = '0;
    cnt_nxt           = cnt_r;
    first_pending_nxt = first_pending_r;
    bypass_nxt        = bypass_r;
    case (state_r)
      S_IDLE: begin
        lane_ctl.load = accept;
        cnt_nxt       = '0;
        if (accept) begin
          bypass_nxt        = first_pending_r | in_restart;
          first_pending_nxt = 1'b0;
        end
      end
      S_MUL: begin
        lane_ctl.step = 1'b1;
        lane_ctl.rnd  = (cnt_r == CNT_W'(RND_STEP));
        lane_ctl.last = mul_last;
        cnt_nxt       = cnt_r + 1'b1;
      end
      S_FIN: begin
        lane_ctl.commit = slot_free;
        lane_ctl.bypass = bypass_r;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
    out_valid_nxt = lane_ctl.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      cnt_r           <= '0;
      first_pending_r <= 1'b1;
      bypass_r        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      cnt_r           <= cnt_nxt;
      first_pending_r <= first_pending_nxt;
      bypass_r        <= bypass_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  assign lane_in[0] = in_x_sample;
  assign lane_in[1] = in_y_sample;
  assign lane_in[2] = in_z_sample;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    lpf3_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .coef_b   (coef_b),
      .sample   (lane_in[g]),
      .filtered (lane_out[g])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_x_filtered = lane_out[0];
  assign out_y_filtered = lane_out[1];
  assign out_z_filtered = lane_out[2];

  // a commit never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctl.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

  // an accepted request starts the multiply from the first bit
  a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MUL) && (cnt_r == '0))
    else $error("multiply did not start");

  // a new result appears only after a commit cycle
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result without commit");

  // the coefficient never exceeds one
  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    coef_ready |-> (coef_b <= B_W'(31'h40000000)))
    else $error("coefficient out of range");

endmodule
